### hdl/blo_pkg.sv
// Shared types and constants for the bounded ordered list engine.
`timescale 1ns / 1ps

package blo_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT_AT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ERASE_AT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ERASE_ALL = 3'd4;
    localparam logic [MODE_W-1:0] MODE_FIND      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_COMPARE
    } t_cell_op;

    // Broadcast to every cell.
    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         pos;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] key;
    } t_cell_cmd;

    // Collected from the row.
    typedef struct packed {
        logic                     any_hit;
        logic [IDX_W-1:0]         first_hit;
        logic signed [DATA_W-1:0] sel_data;
    } t_row_stat;

endpackage

### hdl/blo_cell.sv
// One list slot: holds a word, shifts with its neighbors, compares against the key.
`timescale 1ns / 1ps

module blo_cell
    import blo_pkg::*;
(
    input  logic                     i_clk,
    input  logic [IDX_W-1:0]         i_self,
    input  t_cell_cmd                i_cmd,
    input  logic signed [DATA_W-1:0] i_left,
    input  logic signed [DATA_W-1:0] i_right,
    output logic signed [DATA_W-1:0] o_data,
    output logic signed [DATA_W-1:0] o_sel_data,
    output logic                     o_hit
);

    logic signed [DATA_W-1:0] r_data;
    logic                     r_hit;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CELL_INSERT: begin
                if (i_self > i_cmd.pos) begin
                    r_data <= i_left;
                end else if (i_self == i_cmd.pos) begin
                    r_data <= i_cmd.key;
                end
            end
            CELL_REMOVE: begin
                if (i_self >= i_cmd.pos) begin
                    r_data <= i_right;
                end
            end
            CELL_COMPARE: begin
                r_hit <= ({1'b0, i_self} < i_cmd.count) && (r_data == i_cmd.key);
            end
            default: begin
            end
        endcase
    end

    assign o_data     = r_data;
    assign o_sel_data = (i_self == i_cmd.pos) ? r_data : '0;
    assign o_hit      = r_hit;

endmodule

### hdl/blo_cell_row.sv
// Row of list cells with the select-OR and first-hit encoder.
`timescale 1ns / 1ps

module blo_cell_row
    import blo_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    output t_row_stat o_stat
);

    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_sel  [CAPACITY];
    logic [CAPACITY-1:0]      w_hit;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_left;
        logic signed [DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        blo_cell u_cell (
            .i_clk      (i_clk),
            .i_self     (IDX_W'(g)),
            .i_cmd      (i_cmd),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_data     (w_data[g]),
            .o_sel_data (w_sel[g]),
            .o_hit      (w_hit[g])
        );
    end

    always_comb begin
        o_stat.sel_data  = '0;
        o_stat.any_hit   = |w_hit;
        o_stat.first_hit = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_stat.sel_data = o_stat.sel_data | w_sel[k];
        end
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (w_hit[k]) begin
                o_stat.first_hit = IDX_W'(k);
            end
        end
    end

endmodule

### hdl/bounded_ordered_list_engine_core.sv
// Top level of the bounded ordered list engine: sequencer, count and result registers.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// command   in         i_start, o_busy           i_mode, i_index, i_value
// result    out        o_done (one-cycle strobe) o_status, o_result_value,
//                                                o_result_index, o_entry_count
//
// Append, insert-at, pop and erase-at: accept, then execute.
// Find: accept, compare in every cell, encode first hit.
// Erase-all: accept, then repeat until no hit: each pass compares in the cells,
// then removes the first hit by a left shift of the cells behind it.
// Reset clears the sequencer and the entry count; cell contents stay undefined.
// The receiver cannot stall: o_done is high for exactly one cycle per result.

module bounded_ordered_list_engine_core
    import blo_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [MODE_W-1:0]        i_mode,
    input  logic [IDX_W-1:0]         i_index,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_busy,
    output logic                     o_done,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic [IDX_W-1:0]         o_result_index,
    output logic [CNT_W-1:0]         o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_EXEC
    } t_state;

    t_state                   r_state,  n_state;
    logic [MODE_W-1:0]        r_mode;
    logic [IDX_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]         r_count,  n_count;
    logic                     r_erased, n_erased;
    logic                     r_done,   n_done;
    logic [STAT_W-1:0]        r_status, n_status;
    logic signed [DATA_W-1:0] r_rval,   n_rval;
    logic [IDX_W-1:0]         r_ridx,   n_ridx;

    t_cell_cmd w_cmd;
    t_row_stat w_stat;
    logic      w_accept;
    logic      w_full;
    logic      w_idx_past;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_full     = (r_count >= CNT_W'(CAPACITY));
    assign w_idx_past = ({1'b0, r_idx} >= r_count);

    blo_cell_row u_row (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .o_stat (w_stat)
    );

    // Next-state and cell command. Cells only act in S_CMP and S_EXEC.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_erased   = r_erased;
        n_done     = 1'b0;
        n_status   = ST_OK;
        n_rval     = '0;
        n_ridx     = '0;
        w_cmd.op    = CELL_HOLD;
        w_cmd.pos   = '0;
        w_cmd.count = r_count;
        w_cmd.key   = r_key;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_erased = 1'b0;
                    if (i_mode == MODE_FIND || i_mode == MODE_ERASE_ALL) begin
                        n_state = S_CMP;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_CMP: begin
                w_cmd.op = CELL_COMPARE;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                case (r_mode)
                    MODE_APPEND, MODE_INSERT_AT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_cmd.op = CELL_INSERT;
                            // append, or insert-at past the end, lands at the tail
                            if (r_mode == MODE_APPEND || w_idx_past) begin
                                w_cmd.pos = r_count[IDX_W-1:0];
                            end else begin
                                w_cmd.pos = r_idx;
                            end
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    MODE_POP: begin
                        if (r_count == '0) begin
                            n_status = ST_MISS;
                        end else begin
                            w_cmd.pos = IDX_W'(r_count - CNT_W'(1));
                            n_rval    = w_stat.sel_data;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    MODE_ERASE_AT: begin
                        if (w_idx_past) begin
                            n_status = ST_MISS;
                        end else begin
                            w_cmd.op  = CELL_REMOVE;
                            w_cmd.pos = r_idx;
                            n_rval    = w_stat.sel_data;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    MODE_ERASE_ALL: begin
                        if (w_stat.any_hit) begin
                            // drop the first copy, then compare again
                            w_cmd.op  = CELL_REMOVE;
                            w_cmd.pos = w_stat.first_hit;
                            n_count   = r_count - CNT_W'(1);
                            n_erased  = 1'b1;
                            n_state   = S_CMP;
                            n_done    = 1'b0;
                        end else begin
                            n_status = r_erased ? ST_OK : ST_MISS;
                        end
                    end
                    MODE_FIND: begin
                        if (w_stat.any_hit) begin
                            n_ridx = w_stat.first_hit;
                        end else begin
                            n_status = ST_MISS;
                        end
                    end
                    default: begin
                        n_status = ST_MISS;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_erased <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_erased <= n_erased;
            r_done   <= n_done;
        end
        if (w_accept) begin
            r_mode <= i_mode;
            r_idx  <= i_index;
            r_key  <= i_value;
        end
        r_status <= n_status;
        r_rval   <= n_rval;
        r_ridx   <= n_ridx;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_value = r_rval;
    assign o_result_index = r_ridx;
    assign o_entry_count  = r_count;

`ifndef SYNTH
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_state) == S_EXEC))
        else $error("result strobe without an execute cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_busy)
        else $error("accepted transaction did not raise busy");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> ($past(r_count) == r_count))
        else $error("entry count changed while idle");
`endif

endmodule

### tb/bounded_ordered_list_engine_core_tb.sv
// Self-checking testbench for the bounded ordered list engine core.
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core_tb;
    import blo_pkg::*;

    // Codes with no operation behind them: the core must answer with a miss.
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int TARGET_ITEMS  = 1050;
    // Slowest transaction: erase-all of a full list.
    // The end-of-run quiet window covers that.
    localparam int SETTLE_CYCLES = 140;
    // Cycles with neither a command nor a result accepted. The limit allows
    // the slowest erase-all plus the longest sender gap many times over.
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic [MODE_W-1:0]        i_mode;
    logic [IDX_W-1:0]         i_index;
    logic signed [DATA_W-1:0] i_value;
    logic                     o_busy;
    logic                     o_done;
    logic [STAT_W-1:0]        o_status;
    logic signed [DATA_W-1:0] o_result_value;
    logic [IDX_W-1:0]         o_result_index;
    logic [CNT_W-1:0]         o_entry_count;

    bounded_ordered_list_engine_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_mode         (i_mode),
        .i_index        (i_index),
        .i_value        (i_value),
        .o_busy         (o_busy),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_result_index (o_result_index),
        .o_entry_count  (o_entry_count)
    );

    // Shadow of the list contents as the core should hold them.
    logic [DATA_W-1:0] list_words [CAPACITY];
    int unsigned       word_count;
    int unsigned       deepest_list;

    // Results still owed by the core, oldest first.
    t_list_result expected_results [$];

    int error_count;
    int sent_count;
    int mode_tally [8];
    int full_tally;
    int miss_tally;
    int burst_left;
    int stall_cycles;

    logic [DATA_W-1:0] value_pool [8];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the shadow list and returns the
    // result the core must produce for it.
    // ------------------------------------------------------------------
    function automatic t_list_result predict_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic [IDX_W-1:0]  idx,
                                                     input logic [DATA_W-1:0] val);
        t_list_result r;
        int           k;
        int           kept;
        int           hit_pos;
        r = '{status: ST_OK, value: '0, index: '0, count: '0};
        case (mode)
            MODE_APPEND: begin
                if (word_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[word_count] = val;
                    word_count++;
                end
            end
            MODE_INSERT_AT: begin
                if (word_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    // An index at or past the end degenerates into an append.
                    if (idx < word_count) begin
                        for (k = word_count; k > idx; k--)
                            list_words[k] = list_words[k - 1];
                        list_words[idx] = val;
                    end else begin
                        list_words[word_count] = val;
                    end
                    word_count++;
                end
            end
            MODE_POP: begin
                if (word_count == 0) begin
                    r.status = ST_MISS;
                end else begin
                    word_count--;
                    r.value = list_words[word_count];
                end
            end
            MODE_ERASE_AT: begin
                if (idx >= word_count) begin
                    r.status = ST_MISS;
                end else begin
                    r.value = list_words[idx];
                    for (k = idx; k + 1 < word_count; k++)
                        list_words[k] = list_words[k + 1];
                    word_count--;
                end
            end
            MODE_ERASE_ALL: begin
                // Compacting pass: same final order as repeated first-hit removal.
                kept = 0;
                for (k = 0; k < word_count; k++) begin
                    if (list_words[k] != val) begin
                        list_words[kept] = list_words[k];
                        kept++;
                    end
                end
                if (kept == word_count)
                    r.status = ST_MISS;
                word_count = kept;
            end
            MODE_FIND: begin
                hit_pos = -1;
                for (k = word_count - 1; k >= 0; k--)
                    if (list_words[k] == val)
                        hit_pos = k;
                if (hit_pos < 0)
                    r.status = ST_MISS;
                else
                    r.index = hit_pos[IDX_W-1:0];
            end
            default: begin
                r.status = ST_MISS;
            end
        endcase
        r.count = word_count[CNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of back-to-back commands separated by random gaps.
    // Fields change at the falling edge; the transaction is taken at the
    // first rising edge that sees o_busy low.
    // ------------------------------------------------------------------
    task automatic send_cmd(input logic [MODE_W-1:0] mode,
                            input logic [IDX_W-1:0]  idx,
                            input logic [DATA_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            i_start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            // Mostly short bursts, now and then a long run with no idling.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_mode  <= mode;
        i_index <= idx;
        i_value <= val;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        expected_results.push_back(predict_list_op(mode, idx, val));
        sent_count++;
        mode_tally[mode]++;
        if (word_count > deepest_list)
            deepest_list = word_count;
    endtask

    // Hold the sender off until the core has answered everything.
    task automatic drain_results();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        // Mostly pool values so find and erase-all actually hit.
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if (word_count > 0 && $urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, word_count - 1));
        return IDX_W'($urandom_range(0, CAPACITY - 1));
    endfunction

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Every removing or searching operation on an empty list, plus the two
    // unused mode codes.
    task automatic test_empty_list();
        send_cmd(MODE_POP,       '0,          '0);
        send_cmd(MODE_ERASE_AT,  '0,          '0);
        send_cmd(MODE_ERASE_AT,  '1,          '1);
        send_cmd(MODE_ERASE_ALL, '0,          32'h0000_0000);
        send_cmd(MODE_FIND,      '0,          32'hffff_ffff);
        send_cmd(MODE_RSVD6,     6'd5,        32'h1234_5678);
        send_cmd(MODE_RSVD7,     '1,          32'h8000_0000);
    endtask

    // Word extremes, insert at front / middle / past the end, find hit and
    // miss, erase-at in and out of range, erase-all with duplicates, pops.
    task automatic test_basic_ops();
        send_cmd(MODE_APPEND,    '0,   32'h8000_0000);
        send_cmd(MODE_APPEND,    '0,   32'h7fff_ffff);
        send_cmd(MODE_INSERT_AT, 6'd0, 32'hffff_ffff);
        send_cmd(MODE_INSERT_AT, 6'd2, 32'h0000_0000);
        send_cmd(MODE_INSERT_AT, '1,   32'h0000_0005);
        send_cmd(MODE_APPEND,    '0,   32'h0000_0005);
        send_cmd(MODE_FIND,      '0,   32'h0000_0005);
        send_cmd(MODE_FIND,      '0,   32'h0001_2345);
        send_cmd(MODE_ERASE_AT,  '1,   '0);
        send_cmd(MODE_ERASE_AT,  6'd0, '0);
        send_cmd(MODE_ERASE_ALL, '0,   32'h0000_0005);
        send_cmd(MODE_ERASE_ALL, '0,   32'h0000_0005);
        send_cmd(MODE_POP,       '0,   '0);
        send_cmd(MODE_FIND,      '0,   32'h8000_0000);
        send_cmd(MODE_INSERT_AT, 6'd1, 32'h5555_5555);
        send_cmd(MODE_POP,       '0,   '0);
        send_cmd(MODE_POP,       '0,   '0);
        send_cmd(MODE_POP,       '0,   '0);
        send_cmd(MODE_POP,       '0,   '0);
    endtask

    // Fill to capacity with few distinct words, hit the full-list rejection
    // on both adding operations, then run erase-all passes that each remove
    // many copies and pop the rest until the list is empty.
    task automatic test_full_list();
        logic [DATA_W-1:0] fill_words [3];
        int                n;
        fill_words[0] = $urandom;
        fill_words[1] = 32'h8000_0000;
        fill_words[2] = $urandom;
        while (word_count < CAPACITY) begin
            if ($urandom_range(0, 1) == 0)
                send_cmd(MODE_APPEND, '0, fill_words[$urandom_range(0, 2)]);
            else
                send_cmd(MODE_INSERT_AT, IDX_W'($urandom),
                         fill_words[$urandom_range(0, 2)]);
        end
        send_cmd(MODE_APPEND,    '0,   32'h7fff_ffff);
        send_cmd(MODE_INSERT_AT, 6'd0, 32'h7fff_ffff);
        send_cmd(MODE_INSERT_AT, '1,   32'h7fff_ffff);
        send_cmd(MODE_FIND,      '0,   fill_words[2]);
        send_cmd(MODE_ERASE_AT,  '1,   '0);
        send_cmd(MODE_ERASE_AT,  6'd0, '0);
        send_cmd(MODE_INSERT_AT, 6'd10, 32'h7fff_ffff);
        send_cmd(MODE_INSERT_AT, 6'd62, 32'h0000_0001);
        send_cmd(MODE_APPEND,    '0,   32'h0000_0002);
        for (n = 0; n < 3; n++)
            send_cmd(MODE_ERASE_ALL, '0, fill_words[n]);
        while (word_count > 0)
            send_cmd(MODE_POP, '0, '0);
        send_cmd(MODE_POP, '0, '0);
    endtask

    // Mixed traffic in alternating growth and shrink phases so the list
    // length sweeps between empty and full many times.
    task automatic test_random_traffic();
        int add_weight;
        int phase_len;
        int r;
        int n;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (n = 4; n < 8; n++)
            value_pool[n] = $urandom;
        add_weight = 65;
        while (sent_count < TARGET_ITEMS) begin
            phase_len = $urandom_range(60, 150);
            for (n = 0; n < phase_len && sent_count < TARGET_ITEMS; n++) begin
                if ($urandom_range(0, 99) < add_weight) begin
                    if ($urandom_range(0, 1) == 0)
                        send_cmd(MODE_APPEND, IDX_W'($urandom), pick_value());
                    else
                        send_cmd(MODE_INSERT_AT, pick_index(), pick_value());
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 22)
                        send_cmd(MODE_POP, IDX_W'($urandom), $urandom);
                    else if (r < 44)
                        send_cmd(MODE_ERASE_AT, pick_index(), $urandom);
                    else if (r < 60)
                        send_cmd(MODE_ERASE_ALL, IDX_W'($urandom), pick_value());
                    else if (r < 95)
                        send_cmd(MODE_FIND, IDX_W'($urandom), pick_value());
                    else
                        send_cmd($urandom_range(0, 1) ? MODE_RSVD6 : MODE_RSVD7,
                                 IDX_W'($urandom), $urandom);
                end
            end
            add_weight = (add_weight > 50) ? $urandom_range(15, 35) : $urandom_range(60, 80);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected result at %0t: status %0d value %h",
                             $realtime, o_status, o_result_value,
                             " index %0d count %0d", o_result_index, o_entry_count);
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.status == ST_FULL)
                    full_tally++;
                if (exp_r.status == ST_MISS)
                    miss_tally++;
                if (o_status !== exp_r.status || o_result_value !== exp_r.value ||
                    o_result_index !== exp_r.index || o_entry_count !== exp_r.count) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch at %0t: exp st %0d val %h idx %0d cnt %0d,",
                                 $realtime, exp_r.status, exp_r.value, exp_r.index,
                                 exp_r.count,
                                 " got st %0d val %h idx %0d cnt %0d",
                                 o_status, o_result_value, o_result_index,
                                 o_entry_count);
                end
            end
        end
    end

    // Watchdog: any cycle that moves a transaction either way resets it.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_done === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("bounded_ordered_list_engine_core_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_mode       = MODE_APPEND;
        i_index      = '0;
        i_value      = '0;
        word_count   = 0;
        deepest_list = 0;
        error_count  = 0;
        sent_count   = 0;
        full_tally   = 0;
        miss_tally   = 0;
        burst_left   = 0;
        stall_cycles = 0;
        foreach (mode_tally[m]) mode_tally[m] = 0;
        foreach (list_words[w]) list_words[w] = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_basic_ops();
        // Let the pipeline run dry once before the long sequences.
        drain_results();
        test_full_list();
        test_random_traffic();

        drain_results();
        // Quiet window: catches results the core should never have produced.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            error_count += expected_results.size();

        $display("%0d transactions: %0d append, %0d insert-at, %0d pop, %0d erase-at,",
                 sent_count, mode_tally[MODE_APPEND], mode_tally[MODE_INSERT_AT],
                 mode_tally[MODE_POP], mode_tally[MODE_ERASE_AT],
                 " %0d erase-all, %0d find, %0d reserved",
                 mode_tally[MODE_ERASE_ALL], mode_tally[MODE_FIND],
                 mode_tally[MODE_RSVD6] + mode_tally[MODE_RSVD7]);
        $display("%0d full-list rejections, %0d misses, list depth up to %0d, %0d errors",
                 full_tally, miss_tally, deepest_list, error_count);
        if (error_count == 0)
            $display("bounded_ordered_list_engine_core_tb OK");
        else
            $display("bounded_ordered_list_engine_core_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
hdl/blo_pkg.sv
hdl/blo_cell.sv
hdl/blo_cell_row.sv
hdl/bounded_ordered_list_engine_core.sv
tb/bounded_ordered_list_engine_core_tb.sv
